// ===== rtl/core/dssm_pkg.sv =====
// Shared types and codes for the dual-stack shared-memory block.
package dssm_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_ONE = 3'd0,
        OP_PUSH_TWO = 3'd1,
        OP_POP_ONE  = 3'd2,
        OP_POP_TWO  = 3'd3,
        OP_DUMP_ONE = 3'd4,
        OP_DUMP_TWO = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

endpackage

// ===== rtl/core/dssm_ram.sv =====
// Single-port synchronous word memory with a registered read port.
module dssm_ram
    import dssm_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                       clk,
    input  mem_cmd_t                   cmd,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [WORD_W-1:0]          wdata,
    output logic [WORD_W-1:0]          rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        // hold read data until the next read
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dssm_ctrl.sv =====
// Sequencer: stack pointers, operation decode, dump streaming and output register.
module dssm_ctrl
    import dssm_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [2:0]                 operation,
    input  logic signed [WORD_W-1:0]   push_value,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic signed [WORD_W-1:0]   result_value,
    output logic [1:0]                 status,
    output logic                       last,
    output mem_cmd_t                   mem_cmd,
    output logic [$clog2(DEPTH)-1:0]   mem_addr,
    output logic [WORD_W-1:0]          mem_wdata,
    input  logic [WORD_W-1:0]          mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     lower_reg, lower_next;
    logic [CW-1:0]     upper_reg, upper_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic              down_reg, down_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [WORD_W-1:0] value_reg, value_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              accept;
    logic              full;
    logic [CW:0]       fill;
    logic [AW-1:0]     push_one_addr, push_two_addr, top_one_addr, top_two_addr;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !(state_reg == S_IDLE && !pend_reg && out_free);
    assign accept    = req_valid && !req_stall;

    assign fill = {1'b0, lower_reg} + {1'b0, upper_reg};
    assign full = (fill >= DEPTH_S);

    assign push_one_addr = lower_reg[AW-1:0];
    assign push_two_addr = AW'(DEPTH_C - upper_reg - CW'(1));
    assign top_one_addr  = AW'(lower_reg - CW'(1));
    assign top_two_addr  = AW'(DEPTH_C - upper_reg);

    assign mem_wdata = push_value;

    always_comb
    begin
        state_next     = state_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        addr_next      = addr_reg;
        remain_next    = remain_reg;
        down_next      = down_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        rsp_valid_next = rsp_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        mem_cmd        = '0;
        mem_addr       = addr_reg;

        // drop the output word once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // advance read data into the output register
        if (pend_reg && out_free)
        begin
            rsp_valid_next = 1'b1;
            value_next     = mem_rdata;
            status_next    = ST_OK;
            last_next      = pend_last_reg;
            pend_next      = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(operation))
                        OP_PUSH_ONE, OP_PUSH_TWO:
                        begin
                            rsp_valid_next = 1'b1;
                            value_next     = '0;
                            last_next      = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                mem_cmd.wr  = 1'b1;
                                if (op_t'(operation) == OP_PUSH_ONE)
                                begin
                                    mem_addr   = push_one_addr;
                                    lower_next = lower_reg + CW'(1);
                                end
                                else
                                begin
                                    mem_addr   = push_two_addr;
                                    upper_next = upper_reg + CW'(1);
                                end
                            end
                        end
                        OP_POP_ONE, OP_DUMP_ONE:
                        begin
                            if (lower_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                value_next     = '0;
                                status_next    = ST_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                mem_cmd.rd = 1'b1;
                                mem_addr   = top_one_addr;
                                pend_next  = 1'b1;
                                if (op_t'(operation) == OP_POP_ONE)
                                begin
                                    pend_last_next = 1'b1;
                                    lower_next     = lower_reg - CW'(1);
                                end
                                else
                                begin
                                    pend_last_next = (lower_reg == CW'(1));
                                    addr_next      = top_one_addr - AW'(1);
                                    remain_next    = lower_reg - CW'(1);
                                    down_next      = 1'b1;
                                    if (lower_reg != CW'(1))
                                    begin
                                        state_next = S_STREAM;
                                    end
                                end
                            end
                        end
                        OP_POP_TWO, OP_DUMP_TWO:
                        begin
                            if (upper_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                value_next     = '0;
                                status_next    = ST_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                mem_cmd.rd = 1'b1;
                                mem_addr   = top_two_addr;
                                pend_next  = 1'b1;
                                if (op_t'(operation) == OP_POP_TWO)
                                begin
                                    pend_last_next = 1'b1;
                                    upper_next     = upper_reg - CW'(1);
                                end
                                else
                                begin
                                    pend_last_next = (upper_reg == CW'(1));
                                    addr_next      = top_two_addr + AW'(1);
                                    remain_next    = upper_reg - CW'(1);
                                    down_next      = 1'b0;
                                    if (upper_reg != CW'(1))
                                    begin
                                        state_next = S_STREAM;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            // unused codes: no word, no change
                        end
                    endcase
                end
            end
            S_STREAM:
            begin
                // issue the next read when the pending slot frees up
                if (!pend_reg || out_free)
                begin
                    mem_cmd.rd     = 1'b1;
                    mem_addr       = addr_reg;
                    pend_next      = 1'b1;
                    pend_last_next = (remain_reg == CW'(1));
                    remain_next    = remain_reg - CW'(1);
                    addr_next      = down_reg ? addr_reg - AW'(1) : addr_reg + AW'(1);
                    if (remain_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lower_reg     <= '0;
            upper_reg     <= '0;
            addr_reg      <= '0;
            remain_reg    <= '0;
            down_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            value_reg     <= '0;
            status_reg    <= ST_OK;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            addr_reg      <= addr_next;
            remain_reg    <= remain_next;
            down_reg      <= down_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            rsp_valid_reg <= rsp_valid_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/core/dual_stack_shared_memory.sv =====
// Top level: two stacks sharing one word memory, one growing up and one growing down.
// Timing: push and empty/full results go straight into the output register; pop and dump
//   words pass the memory read register; a dump gives one word per cycle unless stalled.
// Flow: a push takes the next request once the output register is free; pop and dump
//   stall new requests until their last word has left memory for the output register.
// Reset: rst_n clears both stack counts and the output register; memory is not cleared.
module dual_stack_shared_memory
    import dssm_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [2:0]                 operation,
    input  logic signed [WORD_W-1:0]   push_value,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic signed [WORD_W-1:0]   result_value,
    output logic [1:0]                 status,
    output logic                       last
);

    // Memory side: the sequencer owns every access; pushes write, pops and dumps read.
    mem_cmd_t                  mem_cmd;
    logic [$clog2(DEPTH)-1:0]  mem_addr;
    logic [WORD_W-1:0]         mem_wdata;
    logic [WORD_W-1:0]         mem_rdata;

    // Sequencer: decodes each word, keeps both stack counts, streams dumps and
    // holds one read word pending behind the output register so the stream keeps
    // one word per cycle while the consumer takes every word.
    dssm_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .push_value   (push_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_value (result_value),
        .status       (status),
        .last         (last),
        .mem_cmd      (mem_cmd),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

    // Shared storage: stack one fills from entry 0, stack two from entry DEPTH-1.
    dssm_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// ===== rtl/core/dssm_checker.sv =====
// Port-level checks for the dual-stack shared-memory block, bound to the top level.
module dssm_checker
    import dssm_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic [2:0]                 operation,
    input logic signed [WORD_W-1:0]   push_value,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input logic signed [WORD_W-1:0]   result_value,
    input logic [1:0]                 status,
    input logic                       last
);

    // hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(result_value)
            && $stable(status) && $stable(last))
        else $error("output word changed while stalled");

    // refusals and empty results carry a zero value and close the item
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> last && result_value == '0)
        else $error("non-ok word without last or with nonzero value");

    // no new word enters while a dump still has words to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> req_stall)
        else $error("input accepted in the middle of a dump");

    // a push answers in the next cycle with a single zero-valued word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (operation == OP_PUSH_ONE || operation == OP_PUSH_TWO)
            |=> rsp_valid && last && result_value == '0 && status != ST_EMPTY)
        else $error("push result missing or malformed");

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (.*);

// ===== tb/sv/tb_dual_stack_shared_memory.sv =====
// Self-checking testbench for the dual-stack shared-memory block: random traffic, scoreboard.
module tb_dual_stack_shared_memory;
    import dssm_pkg::*;

    localparam int DEPTH       = 32;
    localparam int RANDOM_WORDS = 410;
    // Worst case: every word a 32-deep dump, each result held by a long stall.
    localparam int CYCLE_LIMIT = 600000;

    // One expected result word.
    typedef struct packed {
        logic [WORD_W-1:0] value;
        status_t           st;
        logic              lst;
    } stack_word_t;

    // Predicts both stacks and holds the result words still owed by the block.
    class stack_scoreboard;
        logic [WORD_W-1:0] store [DEPTH];
        int                lower_count;
        int                upper_count;
        stack_word_t       awaited[$];
        int                errors;

        function new();
            lower_count = 0;
            upper_count = 0;
            errors      = 0;
        endfunction

        function bit is_full();
            return (lower_count + upper_count) >= DEPTH;
        endfunction

        function void add_word(logic [WORD_W-1:0] value, status_t st, logic lst);
            stack_word_t w;
            w.value = value;
            w.st    = st;
            w.lst   = lst;
            awaited.push_back(w);
        endfunction

        function void note_request(logic [2:0] op, logic [WORD_W-1:0] val);
            bit full;
            full = is_full();
            case (op)
                OP_PUSH_ONE, OP_PUSH_TWO:
                begin
                    if (full)
                        add_word('0, ST_FULL, 1'b1);
                    else
                    begin
                        if (op == OP_PUSH_ONE)
                        begin
                            store[lower_count] = val;
                            lower_count++;
                        end
                        else
                        begin
                            upper_count++;
                            store[DEPTH - upper_count] = val;
                        end
                        add_word('0, ST_OK, 1'b1);
                    end
                end
                OP_POP_ONE:
                begin
                    if (lower_count == 0)
                        add_word('0, ST_EMPTY, 1'b1);
                    else
                    begin
                        lower_count--;
                        add_word(store[lower_count], ST_OK, 1'b1);
                    end
                end
                OP_POP_TWO:
                begin
                    if (upper_count == 0)
                        add_word('0, ST_EMPTY, 1'b1);
                    else
                    begin
                        add_word(store[DEPTH - upper_count], ST_OK, 1'b1);
                        upper_count--;
                    end
                end
                OP_DUMP_ONE:
                begin
                    if (lower_count == 0)
                        add_word('0, ST_EMPTY, 1'b1);
                    else
                        for (int i = lower_count; i > 0; i--)
                            add_word(store[i - 1], ST_OK, i == 1);
                end
                OP_DUMP_TWO:
                begin
                    if (upper_count == 0)
                        add_word('0, ST_EMPTY, 1'b1);
                    else
                        for (int i = DEPTH - upper_count; i < DEPTH; i++)
                            add_word(store[i], ST_OK, i == DEPTH - 1);
                end
                default: ;
            endcase
        endfunction

        function void check_response(logic [WORD_W-1:0] value, logic [1:0] st, logic lst);
            stack_word_t w;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected word: value %h status %0d last %b",
                         $time, value, st, lst);
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (value !== w.value)
            begin
                $display("%0t: result_value expected %h got %h", $time, w.value, value);
                errors++;
            end
            if (st !== w.st)
            begin
                $display("%0t: status expected %0d got %0d", $time, w.st, st);
                errors++;
            end
            if (lst !== w.lst)
            begin
                $display("%0t: last expected %b got %b", $time, w.lst, lst);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] push_value;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic signed [WORD_W-1:0] result_value;
    logic [1:0]               status;
    logic                     last;

    stack_scoreboard sb = new();

    // Idle percentages for each side; the main sequence changes them per phase.
    int send_idle_pct;
    int recv_idle_pct;
    // Count of accepted words that the block answers (unused codes do not count).
    int counted_words;
    int cycle_count;

    dual_stack_shared_memory #(
        .DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .push_value   (push_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_value (result_value),
        .status       (status),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: check every accepted result word, then pick the stall for the next edge.
    // Sampling at the rising edge sees the values from before the block updates.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(result_value, status, last);
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one word and hold it until the block takes it. Idle cycles go first,
    // so valid only drops when a gap is actually inserted.
    task automatic send_word(input logic [2:0] op, input logic [WORD_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        operation  <= op;
        push_value <= val;
        // Hold the payload until an edge sees the block ready.
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(op, val);
        if (op <= OP_DUMP_TWO)
            counted_words++;
    endtask

    // Random data, with the sign and all-ones/all-zeros corners mixed in.
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(1) ? OP_PUSH_ONE : OP_PUSH_TWO;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(1) ? OP_POP_ONE : OP_POP_TWO;
    endfunction

    // Short fixed sequence: empty cases, unused codes, data extremes on both stacks.
    task automatic run_directed();
        send_word(OP_POP_ONE, 32'h1234_5678);
        send_word(OP_POP_TWO, 32'h0);
        send_word(OP_DUMP_ONE, 32'h0);
        send_word(OP_DUMP_TWO, 32'h0);
        send_word(3'd6, 32'hdead_beef);
        send_word(3'd7, 32'hffff_ffff);
        send_word(OP_PUSH_ONE, 32'h7fff_ffff);
        send_word(OP_PUSH_ONE, 32'h8000_0000);
        send_word(OP_PUSH_ONE, 32'h0000_0000);
        send_word(OP_PUSH_ONE, 32'hffff_ffff);
        send_word(OP_PUSH_TWO, 32'h8000_0000);
        send_word(OP_PUSH_TWO, 32'h7fff_ffff);
        send_word(OP_PUSH_TWO, 32'hffff_ffff);
        send_word(OP_PUSH_TWO, 32'h0000_0000);
        send_word(OP_DUMP_ONE, 32'h0);
        send_word(OP_DUMP_TWO, 32'h0);
        send_word(OP_POP_ONE, 32'h0);
        send_word(OP_POP_TWO, 32'h0);
        send_word(OP_DUMP_ONE, 32'h0);
        send_word(OP_DUMP_TWO, 32'h0);
        send_word(OP_POP_ONE, 32'h0);
        send_word(OP_POP_ONE, 32'h0);
        send_word(OP_POP_ONE, 32'h0);
        send_word(OP_DUMP_ONE, 32'h0);
    endtask

    // Random traffic in bursts until the word count reaches the target:
    //   fill  - push to random sides until the memory is full, push past it, dump both
    //   drain - pop until both stacks are empty, pop past it, dump an empty stack
    //   mixed - any operation, unused codes included
    // Every phase opens with a fill so the full case shows up under each idle pattern.
    task automatic run_bursts(input int target);
        int kind;
        int r;
        int n;
        logic [2:0] op;
        kind = 0;
        while (counted_words < target)
        begin
            if (kind == 0)
            begin
                while (!sb.is_full())
                    send_word(pick_push(), pick_value());
                repeat ($urandom_range(1, 3))
                    send_word(pick_push(), pick_value());
                send_word(OP_DUMP_ONE, pick_value());
                send_word(OP_DUMP_TWO, pick_value());
            end
            else if (kind == 1)
            begin
                while (sb.lower_count > 0 || sb.upper_count > 0)
                    send_word(pick_pop(), pick_value());
                repeat ($urandom_range(1, 2))
                    send_word(pick_pop(), pick_value());
                send_word($urandom_range(1) ? OP_DUMP_ONE : OP_DUMP_TWO, pick_value());
            end
            else
            begin
                n = $urandom_range(8, 24);
                repeat (n)
                begin
                    r = $urandom_range(19);
                    if (r < 4)
                        op = OP_PUSH_ONE;
                    else if (r < 8)
                        op = OP_PUSH_TWO;
                    else if (r < 11)
                        op = OP_POP_ONE;
                    else if (r < 14)
                        op = OP_POP_TWO;
                    else if (r < 16)
                        op = OP_DUMP_ONE;
                    else if (r < 18)
                        op = OP_DUMP_TWO;
                    else
                        op = (r == 18) ? 3'd6 : 3'd7;
                    send_word(op, pick_value());
                end
            end
            kind = $urandom_range(4);
        end
    endtask

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n         <= 1'b0;
        req_valid     <= 1'b0;
        operation     <= OP_PUSH_ONE;
        push_value    <= '0;
        rsp_stall     <= 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 87;
        counted_words = 0;
        cycle_count   = 0;

        // Hold reset low, then release it once for the whole run.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender mostly busy, receiver mostly stalled.
        run_directed();
        run_bursts(RANDOM_WORDS / 3);

        // Phase two: sender mostly idle, receiver mostly ready.
        send_idle_pct = 87;
        recv_idle_pct = 6;
        run_bursts(2 * RANDOM_WORDS / 3);

        // Phase three: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_bursts(RANDOM_WORDS);

        // Drop valid, wait for every owed word, then give the block time to show extras.
        req_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
